@@ rtl/ipv4_hash_set_insert_macros.svh @@
// assertion macros for the ipv4 hash set insert block
// both expect clk and rst_n in the scope of use
`ifndef IPV4_HASH_SET_INSERT_MACROS_SVH
`define IPV4_HASH_SET_INSERT_MACROS_SVH

`ifndef SYNTHESIS

`define IHS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ipv4_hash_set_insert: assertion failed");

`define IHS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ipv4_hash_set_insert: assertion failed");

`else

`define IHS_ASSERT(lbl, prop)

`define IHS_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

@@ rtl/ihs_pkg.sv @@
`default_nettype none

package ihs_pkg;

    localparam int CAPACITY    = 1024;
    localparam int PROBE_LIMIT = 64;
    localparam int HALF        = CAPACITY / 2;

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int PROBE_W = $clog2(PROBE_LIMIT + 1);
    localparam int CNT_W   = $clog2(HALF + 1);

    // fixed result field widths
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_O_W = 10;
    localparam int OCC_W    = 10;

    localparam logic [OCC_W-1:0] HALF_OCC = OCC_W'(HALF);

    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2,
        ST_ZERO     = 2'd3
    } status_code_t;

    typedef struct packed {
        logic         load_addr;
        logic         hash_step;
        logic         mem_rd;
        logic         rehash;
        logic         do_insert;
        logic         res_set;
        status_code_t res_status;
        logic         load_out;
        logic         clear_step;
    } ihs_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic hash_last;
        logic slot_empty;
        logic slot_match;
        logic probe_last;
        logic load_full;
        logic clear_last;
    } ihs_sts_t;

endpackage

`default_nettype wire

@@ rtl/ihs_datapath.sv @@
`default_nettype none

module ihs_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [ihs_pkg::ADDR_W-1:0]     address,
    input  wire ihs_pkg::ihs_cmd_t              cmd,
    output ihs_pkg::ihs_sts_t                   sts,
    output logic      [ihs_pkg::STATUS_W-1:0]   status,
    output logic      [ihs_pkg::SLOT_O_W-1:0]   slot,
    output logic      [ihs_pkg::OCC_W-1:0]      occupancy
);

    logic [ihs_pkg::ADDR_W-1:0] slot_mem [ihs_pkg::CAPACITY];

    logic [31:0]                  key_reg, key_next;
    logic [31:0]                  word_reg, word_next;
    logic [31:0]                  h_reg, h_next;
    logic [1:0]                   byte_idx_reg, byte_idx_next;
    logic [ihs_pkg::PROBE_W-1:0]  probe_reg, probe_next;
    logic [ihs_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [ihs_pkg::SLOT_W-1:0]   clear_reg, clear_next;
    logic [31:0]                  rdata_reg;
    ihs_pkg::status_code_t        res_status_reg, res_status_next;
    logic [ihs_pkg::SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [ihs_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ihs_pkg::SLOT_O_W-1:0] out_slot_reg, out_slot_next;
    logic [ihs_pkg::OCC_W-1:0]    out_occ_reg, out_occ_next;

    logic [7:0]                   hash_byte;
    logic [31:0]                  mult_in;
    logic [31:0]                  product;
    logic [ihs_pkg::SLOT_W-1:0]   hslot;
    logic                         mem_we;
    logic [ihs_pkg::SLOT_W-1:0]   mem_waddr;
    logic [31:0]                  mem_wdata;

    assign hslot     = h_reg[ihs_pkg::SLOT_W-1:0];
    assign hash_byte = word_reg[byte_idx_reg*8 +: 8];
    assign mult_in   = h_reg ^ {24'd0, hash_byte};
    assign product   = mult_in * ihs_pkg::FNV_PRIME;

    always_comb
    begin
        key_next        = key_reg;
        word_next       = word_reg;
        h_next          = h_reg;
        byte_idx_next   = byte_idx_reg;
        probe_next      = probe_reg;
        count_next      = count_reg;
        clear_next      = clear_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_occ_next    = out_occ_reg;

        if (cmd.load_addr)
        begin
            key_next      = address;
            word_next     = address;
            h_next        = ihs_pkg::FNV_BASIS;
            byte_idx_next = 2'd0;
            probe_next    = '0;
        end
        if (cmd.rehash)
        begin
            // next probe hashes the previous hash value
            word_next     = h_reg;
            h_next        = ihs_pkg::FNV_BASIS;
            byte_idx_next = 2'd0;
            probe_next    = probe_reg + 1'b1;
        end
        if (cmd.hash_step)
        begin
            h_next        = product;
            byte_idx_next = byte_idx_reg + 1'b1;
        end
        if (cmd.do_insert)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.clear_step)
        begin
            clear_next = clear_reg + 1'b1;
        end
        if (cmd.res_set)
        begin
            res_status_next = cmd.res_status;
            if (cmd.res_status inside {ihs_pkg::ST_INSERTED, ihs_pkg::ST_PRESENT})
            begin
                res_slot_next = hslot;
            end
            else
            begin
                res_slot_next = '0;
            end
        end
        if (cmd.load_out)
        begin
            out_status_next = res_status_reg;
            out_slot_next   = ihs_pkg::SLOT_O_W'(res_slot_reg);
            out_occ_next    = ihs_pkg::OCC_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg <= 2'd0;
            probe_reg    <= '0;
            count_reg    <= '0;
            clear_reg    <= '0;
        end
        else
        begin
            byte_idx_reg <= byte_idx_next;
            probe_reg    <= probe_next;
            count_reg    <= count_next;
            clear_reg    <= clear_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        word_reg       <= word_next;
        h_reg          <= h_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_occ_reg    <= out_occ_next;
    end

    // one write port shared by the clearing sweep and inserts
    assign mem_we    = cmd.clear_step | cmd.do_insert;
    assign mem_waddr = cmd.clear_step ? clear_reg : hslot;
    assign mem_wdata = cmd.clear_step ? '0 : key_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= slot_mem[hslot];
        end
    end

    assign sts.in_zero    = (address == '0);
    assign sts.hash_last  = (byte_idx_reg == 2'd3);
    assign sts.slot_empty = (rdata_reg == '0);
    assign sts.slot_match = (rdata_reg == key_reg);
    assign sts.probe_last = (probe_reg == ihs_pkg::PROBE_W'(ihs_pkg::PROBE_LIMIT - 1));
    assign sts.load_full  = (count_reg == ihs_pkg::CNT_W'(ihs_pkg::HALF));
    assign sts.clear_last = (clear_reg == '1);

    assign status    = out_status_reg;
    assign slot      = out_slot_reg;
    assign occupancy = out_occ_reg;

endmodule

`default_nettype wire

@@ rtl/ihs_ctrl.sv @@
`default_nettype none

module ihs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire ihs_pkg::ihs_sts_t sts,
    output ihs_pkg::ihs_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res_status = ihs_pkg::ST_INSERTED;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_addr = 1'b1;
                    if (sts.in_zero)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ihs_pkg::ST_ZERO;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.slot_empty)
                begin
                    cmd.res_set = 1'b1;
                    if (sts.load_full)
                    begin
                        cmd.res_status = ihs_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.do_insert  = 1'b1;
                        cmd.res_status = ihs_pkg::ST_INSERTED;
                    end
                    state_next = S_FINISH;
                end
                else if (sts.slot_match)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ihs_pkg::ST_PRESENT;
                    state_next     = S_FINISH;
                end
                else if (sts.probe_last)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ihs_pkg::ST_FULL;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.rehash = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_FINISH:
            begin
                // wait here while the previous result is still held
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/ipv4_hash_set_insert.sv @@
// ipv4 address set insert with open addressing over a 1024-slot table
// input channel: in_valid / in_ready carrying a 32-bit address per request
// output channel: out_valid / out_ready carrying status, slot, occupancy
// after reset the table is swept to empty, one slot per cycle; in_ready
// stays low until the sweep is done
// each probe hashes four bytes through one 32-bit multiplier, one byte per
// cycle, then reads the slot memory into a register and compares it
// requests are taken one at a time: in_ready stays low from accept until
// the result is loaded into the output register; a zero address skips the
// hashing and the table and gives status zero
// the result sits in an output register: a new request is accepted while it
// waits, and the block holds its next result until out_ready frees the
// register
`default_nettype none

`include "ipv4_hash_set_insert_macros.svh"

module ipv4_hash_set_insert (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [ihs_pkg::ADDR_W-1:0]     address,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [ihs_pkg::STATUS_W-1:0]   status,
    output logic      [ihs_pkg::SLOT_O_W-1:0]   slot,
    output logic      [ihs_pkg::OCC_W-1:0]      occupancy
);

    ihs_pkg::ihs_cmd_t cmd;
    ihs_pkg::ihs_sts_t sts;

    ihs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ihs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .address   (address),
        .cmd       (cmd),
        .sts       (sts),
        .status    (status),
        .slot      (slot),
        .occupancy (occupancy)
    );

    `IHS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `IHS_ASSERT(a_insert_guarded, cmd.do_insert |-> (sts.slot_empty && !sts.load_full))
    `IHS_ASSERT(a_occ_bound, out_valid |-> (occupancy <= ihs_pkg::HALF_OCC))

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import ihs_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8 + 6 * PROBE_LIMIT;
    localparam int PLAN_ROWS    = 20;

    typedef struct packed {
        status_code_t          st;
        logic [SLOT_O_W-1:0]   sl;
        logic [OCC_W-1:0]      occ;
    } outcome_t;

    typedef struct packed {
        logic [ADDR_W-1:0]     addr;
        bit                    given;
        status_code_t          st;
        logic [SLOT_O_W-1:0]   sl;
        logic [OCC_W-1:0]      occ;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ADDR_W-1:0]     address = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_O_W-1:0]   slot;
    logic [OCC_W-1:0]      occupancy;

    // shadow of the slot table, updated as each request is accepted
    logic [31:0]           model_slots [CAPACITY];
    int unsigned           model_count;

    outcome_t              predicted_outcomes [$];
    logic [31:0]           seen_addresses [$];

    bit                    steady_run = 1'b0;
    int unsigned           stall_left = 0;
    int unsigned           cycle_count = 0;
    int unsigned           requests_sent = 0;
    int unsigned           results_checked = 0;
    int unsigned           mismatch_count = 0;
    int unsigned           status_seen [4] = '{default: 0};

    // directed requests; the expected result is given only for zero addresses
    plan_row_t directed_plan [PLAN_ROWS] = '{
        '{32'h00000000, 1'b1, ST_ZERO,     10'd0, 10'd0},
        '{32'h00000001, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h00000001, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h00000000, 1'b1, ST_ZERO,     10'd0, 10'd1},
        '{32'hffffffff, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h80000000, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h7fffffff, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h000000ff, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h0000ff00, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h00ff0000, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'hff000000, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'hc0a80001, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h0a000001, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'hffffffff, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h80000000, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h01010101, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'haaaaaaaa, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h55555555, 1'b0, ST_INSERTED, 10'd0, 10'd0},
        '{32'h00000000, 1'b1, ST_ZERO,     10'd0, 10'd13},
        '{32'h55555555, 1'b0, ST_INSERTED, 10'd0, 10'd0}
    };

    ipv4_hash_set_insert uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .address   (address),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .slot      (slot),
        .occupancy (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // fnv-1a over the four bytes of a word, low byte first
    function automatic logic [31:0] fnv_fold(input logic [31:0] word);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int k = 0; k < 4; k++)
        begin
            h = (h ^ {24'd0, word[8*k +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic outcome_t set_insert_predict(input logic [31:0] a);
        outcome_t    r;
        logic [31:0] h;
        int unsigned idx;
        bit          done;
        r.st = ST_FULL;
        r.sl = '0;
        done = 1'b0;
        if (a == 32'd0)
        begin
            r.st = ST_ZERO;
        end
        else
        begin
            h = fnv_fold(a);
            for (int p = 0; p < PROBE_LIMIT && !done; p++)
            begin
                idx = h % CAPACITY;
                if (model_slots[idx] == 32'd0)
                begin
                    // load check only applies once an empty slot is reached
                    if (model_count + 1 <= HALF)
                    begin
                        model_slots[idx] = a;
                        model_count++;
                        r.st = ST_INSERTED;
                        r.sl = SLOT_O_W'(idx);
                    end
                    done = 1'b1;
                end
                else if (model_slots[idx] == a)
                begin
                    r.st = ST_PRESENT;
                    r.sl = SLOT_O_W'(idx);
                    done = 1'b1;
                end
                else
                begin
                    h = fnv_fold(h);
                end
            end
        end
        r.occ = OCC_W'(model_count);
        return r;
    endfunction

    task automatic send_request(input logic [31:0] a, input bit given, input outcome_t fixed);
        int unsigned gap;
        outcome_t    r;
        gap = steady_run ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        address  <= a;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = set_insert_predict(a);
        if (given)
        begin
            r = fixed;
        end
        predicted_outcomes.push_back(r);
        requests_sent++;
    endtask

    task automatic drain_pending();
        in_valid <= 1'b0;
        do @(posedge clk); while (predicted_outcomes.size() != 0);
    endtask

    // result checking and output-side stalls
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                status_seen[status]++;
                if (predicted_outcomes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: result %0d with no request pending: status %0d slot %0d occupancy %0d",
                                 results_checked, status, slot, occupancy);
                end
                else
                begin
                    want = predicted_outcomes.pop_front();
                    if (status !== want.st || slot !== want.sl || occupancy !== want.occ)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: result %0d expected status %0d slot %0d occupancy %0d, got %0d %0d %0d",
                                     results_checked, want.st, want.sl, want.occ,
                                     status, slot, occupancy);
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
            end
            else if (!out_ready)
            begin
                out_ready <= 1'b1;
            end
            else if (out_valid && !steady_run)
            begin
                int unsigned d;
                d = $urandom_range(0, 8);
                if (d != 0)
                begin
                    out_ready  <= 1'b0;
                    stall_left <= d - 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout: %0d results still pending", predicted_outcomes.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] a;
        logic [31:0] target;
        logic [31:0] filler;
        logic [31:0] h;
        int unsigned idx;
        int unsigned pick;

        for (int i = 0; i < CAPACITY; i++)
        begin
            model_slots[i] = 32'd0;
        end
        model_count = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            send_request(directed_plan[i].addr, directed_plan[i].given,
                         {directed_plan[i].st, directed_plan[i].sl, directed_plan[i].occ});
            if (directed_plan[i].addr != 32'd0)
                seen_addresses.push_back(directed_plan[i].addr);
        end
        drain_pending();

        // occupy every slot on one address's probe path so that its insert
        // runs out of probes with no empty slot found
        do target = $urandom; while (target == 32'd0);
        h = fnv_fold(target);
        for (int p = 0; p < PROBE_LIMIT; p++)
        begin
            idx = h % CAPACITY;
            if (model_slots[idx] == 32'd0)
            begin
                do filler = $urandom;
                while (filler == 32'd0 || filler == target || (fnv_fold(filler) % CAPACITY) != idx);
                send_request(filler, 1'b0, '0);
                seen_addresses.push_back(filler);
            end
            h = fnv_fold(h);
        end
        drain_pending();
        send_request(target, 1'b0, '0);

        // fill the table up to the load limit with a mix of traffic
        while (model_count < HALF)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                a = 32'd0;
            else if (pick < 10)
                a = seen_addresses[$urandom_range(0, seen_addresses.size() - 1)];
            else if (pick < 20)
                a = seen_addresses[$urandom_range(0, seen_addresses.size() - 1)]
                    ^ (32'd1 << $urandom_range(0, 31));
            else
                a = $urandom;
            if ($urandom_range(0, 29) == 0)
                steady_run <= !steady_run;
            send_request(a, 1'b0, '0);
            if (a != 32'd0)
                seen_addresses.push_back(a);
        end

        // table at its load limit: new addresses bounce, known ones are found
        repeat (30)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                a = 32'd0;
            else if (pick < 55)
                a = seen_addresses[$urandom_range(0, seen_addresses.size() - 1)];
            else if (pick < 65)
                a = target;
            else
                a = $urandom;
            if ($urandom_range(0, 9) == 0)
                steady_run <= !steady_run;
            send_request(a, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (predicted_outcomes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("coverage: %0d requests, %0d inserted, %0d already present, %0d full, %0d zero",
                 requests_sent, status_seen[ST_INSERTED], status_seen[ST_PRESENT],
                 status_seen[ST_FULL], status_seen[ST_ZERO]);
        $display("coverage: table filled to %0d of %0d slots, one probe path fully occupied",
                 model_count, CAPACITY);
        if (mismatch_count == 0 && predicted_outcomes.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ihs_pkg.sv
rtl/ihs_datapath.sv
rtl/ihs_ctrl.sv
rtl/ipv4_hash_set_insert.sv
tb/sv/testbench.sv
